/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the bitplane pixel store
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define LMBP_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// assertion on the module clock clk and reset arst_n
`define LMBP_ASSERT(label, prop, msg) \
	`LMBP_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

/* design/lmbp_pkg.sv */
// ---------------------------------------------------------------------------
// lmbp_pkg
// word types, op codes and register indexes of the bitplane pixel store
// ---------------------------------------------------------------------------
package lmbp_pkg;

	localparam int ROWS_PER_PLANE = 8;
	localparam int CFG_INDEX_W    = 4;
	localparam int CFG_DATA_W     = 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} lmbp_op_t;

	localparam logic KIND_GRID = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_ROWS = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION  = 4'd1;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic [1:0]        color;
	} lmbp_in_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] grid_index;
		logic [7:0] grid_data;
		logic [1:0] read_color;
		logic       last;
	} lmbp_out_t;

	typedef struct packed {
		logic pix_we;
		logic clr;
	} lmbp_store_ctl_t;

endpackage

/* design/lmbp_map.sv */
// ---------------------------------------------------------------------------
// lmbp_map
// logical to physical pixel mapping: optional row flip, then quarter turns
// ---------------------------------------------------------------------------
module lmbp_map #(
	parameter int MATRIX_WIDTH  = 8,
	parameter int MATRIX_HEIGHT = 8,
	parameter int COL_W         = 3,
	parameter int ROW_W         = 3
) (
	input  logic signed [7:0] x,
	input  logic signed [7:0] y,
	input  logic              flip_rows,
	input  logic [1:0]        rotation_quarters,
	output logic [COL_W-1:0]  px,
	output logic [ROW_W-1:0]  py,
	output logic              ok
);
	import lmbp_pkg::*;

	localparam logic signed [4:0] WM1 = 5'(MATRIX_WIDTH - 1);
	localparam logic signed [4:0] HM1 = 5'(MATRIX_HEIGHT - 1);
	localparam logic signed [4:0] WS  = 5'(MATRIX_WIDTH);
	localparam logic signed [4:0] HS  = 5'(MATRIX_HEIGHT);

	logic              log_ok;
	logic signed [4:0] xs;
	logic signed [4:0] ys;
	logic signed [4:0] yf;
	logic signed [4:0] xr;
	logic signed [4:0] yr;

	always_comb begin
		log_ok = !x[7] && !y[7] && (8'(x) < 8'(MATRIX_WIDTH)) && (8'(y) < 8'(MATRIX_HEIGHT));
		xs = $signed(x[4:0]);
		ys = $signed(y[4:0]);
		yf = flip_rows ? (HM1 - ys) : ys;
		case (rotation_quarters)
			2'd1: begin
				xr = WM1 - yf;
				yr = xs;
			end
			2'd2: begin
				xr = WM1 - xs;
				yr = WM1 - yf;
			end
			2'd3: begin
				xr = yf;
				yr = WM1 - xs;
			end
			default: begin
				xr = xs;
				yr = yf;
			end
		endcase
		ok = log_ok && (xr >= 5'sd0) && (xr < WS) && (yr >= 5'sd0) && (yr < HS);
		px = xr[COL_W-1:0];
		py = yr[ROW_W-1:0];
	end

endmodule

/* design/lmbp_store.sv */
// ---------------------------------------------------------------------------
// lmbp_store
// row registers holding every color plane of one physical row side by side
// ---------------------------------------------------------------------------
module lmbp_store #(
	parameter int MATRIX_WIDTH  = 8,
	parameter int MATRIX_HEIGHT = 8,
	parameter int PLANES        = 2,
	parameter int COL_W         = 3,
	parameter int ROW_W         = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lmbp_pkg::lmbp_store_ctl_t            ctl,
	input  logic [ROW_W-1:0]                     py,
	input  logic [COL_W-1:0]                     px,
	input  logic [1:0]                           color,
	output logic [PLANES-1:0][MATRIX_WIDTH-1:0]  cur_row,
	output logic [PLANES-1:0][MATRIX_WIDTH-1:0]  nxt_row
);
	import lmbp_pkg::*;

	logic [PLANES-1:0][MATRIX_WIDTH-1:0] rows_q [MATRIX_HEIGHT];

	always_comb begin
		cur_row = rows_q[py];
		nxt_row = cur_row;
		for (int p = 0; p < PLANES; p++) begin
			nxt_row[p][px] = color[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MATRIX_HEIGHT; r++) begin
				rows_q[r] <= '0;
			end
		end else if (ctl.clr) begin
			for (int r = 0; r < MATRIX_HEIGHT; r++) begin
				rows_q[r] <= '0;
			end
		end else if (ctl.pix_we) begin
			rows_q[py] <= nxt_row;
		end
	end

endmodule

/* design/led_matrix_bitplane_pixel_store_unit.sv */
// ---------------------------------------------------------------------------
// led_matrix_bitplane_pixel_store_unit
// bitplane frame buffer for a small led matrix with row flip and rotation
//
//   channel  handshake              word
//   cmd      cmd_valid / cmd_stall  lmbp_in_t: op, x, y, color
//   res      res_valid / res_stall  lmbp_out_t: kind, grid_index, grid_data,
//                                   read_color, last
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_value
//
// a command is held in one input register and emits one result word per
// cycle while res is not stalled into the output register: a write emits
// PLANES words, a read one, a clear MATRIX_HEIGHT, a dropped command none
// the next command is taken in the cycle of its last word or its drop
// reset clears the row store and control registers at once, no clearing pass
// a stall on res holds the output word and the command in progress
// ---------------------------------------------------------------------------
module led_matrix_bitplane_pixel_store_unit #(
	parameter int MATRIX_WIDTH  = 8,
	parameter int MATRIX_HEIGHT = 8,
	parameter int PLANES        = 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cmd_valid,
	output logic                                    cmd_stall,
	input  lmbp_pkg::lmbp_in_t                      cmd_word,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output lmbp_pkg::lmbp_out_t                     res_word,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lmbp_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [lmbp_pkg::CFG_DATA_W-1:0]         cfg_value
);
	import lmbp_pkg::*;

	localparam int COL_W = $clog2(MATRIX_WIDTH);
	localparam int ROW_W = $clog2(MATRIX_HEIGHT);
	localparam int CNT_W = $clog2(MATRIX_HEIGHT);

	logic                                 flip_q;
	logic [1:0]                           rot_q;
	logic                                 busy_s1;
	lmbp_in_t                             word_s1;
	logic [CNT_W-1:0]                     cnt_q;
	logic                                 res_valid_q;
	lmbp_out_t                            res_word_q;

	logic [COL_W-1:0]                     px;
	logic [ROW_W-1:0]                     py;
	logic                                 map_ok;
	logic [PLANES-1:0][MATRIX_WIDTH-1:0]  cur_row;
	logic [PLANES-1:0][MATRIX_WIDTH-1:0]  nxt_row;
	lmbp_store_ctl_t                      st_ctl;

	logic                                 cmd_acc;
	logic                                 out_free;
	logic                                 emit;
	logic                                 drop;
	logic                                 done;
	lmbp_out_t                            r;
	logic [1:0]                           rd_color;

	lmbp_map #(
		.MATRIX_WIDTH  (MATRIX_WIDTH),
		.MATRIX_HEIGHT (MATRIX_HEIGHT),
		.COL_W         (COL_W),
		.ROW_W         (ROW_W)
	) u_map (
		.x                 (word_s1.x),
		.y                 (word_s1.y),
		.flip_rows         (flip_q),
		.rotation_quarters (rot_q),
		.px                (px),
		.py                (py),
		.ok                (map_ok)
	);

	lmbp_store #(
		.MATRIX_WIDTH  (MATRIX_WIDTH),
		.MATRIX_HEIGHT (MATRIX_HEIGHT),
		.PLANES        (PLANES),
		.COL_W         (COL_W),
		.ROW_W         (ROW_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.py      (py),
		.px      (px),
		.color   (word_s1.color),
		.cur_row (cur_row),
		.nxt_row (nxt_row)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cmd_stall = busy_s1 && !done;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// result word for the current count
	always_comb begin
		r        = '0;
		rd_color = '0;
		drop     = 1'b0;
		emit     = 1'b0;
		st_ctl   = '0;
		for (int p = 0; p < PLANES; p++) begin
			rd_color[p] = map_ok && cur_row[p][px];
		end
		case (word_s1.op)
			OP_WRITE: begin
				if (map_ok) begin
					emit = busy_s1 && out_free;
					r.kind = KIND_GRID;
					for (int p = 0; p < PLANES; p++) begin
						if (cnt_q == CNT_W'(p)) begin
							r.grid_index = 4'(ROWS_PER_PLANE * p + int'(py));
							r.grid_data  = 8'(nxt_row[p]);
						end
					end
					r.last = (cnt_q == CNT_W'(PLANES - 1));
					st_ctl.pix_we = emit;
				end else begin
					drop = busy_s1;
				end
			end
			OP_READ: begin
				emit = busy_s1 && out_free;
				r.kind = KIND_READ;
				r.read_color = rd_color;
				r.last = 1'b1;
			end
			OP_CLEAR: begin
				emit = busy_s1 && out_free;
				r.kind = KIND_GRID;
				r.grid_index = 4'(cnt_q);
				r.last = (cnt_q == CNT_W'(MATRIX_HEIGHT - 1));
				st_ctl.clr = emit;
			end
			default: begin
				drop = busy_s1;
			end
		endcase
	end

	assign done = drop || (emit && r.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
			rot_q  <= 2'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FLIP_ROWS: flip_q <= cfg_value[0];
				CFG_ROTATION:  rot_q  <= cfg_value[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (cmd_acc || done) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			word_s1 <= cmd_word;
		end
		if (emit) begin
			res_word_q <= r;
		end
	end

	`include "assert_macros.svh"

	`LMBP_ASSERT(a_cnt_range, busy_s1 |-> (int'(cnt_q) < MATRIX_HEIGHT), "count out of range")
	`LMBP_ASSERT(a_read_last, (res_valid_q && res_word_q.kind == KIND_READ) |-> res_word_q.last, "read answer not last")
	`LMBP_ASSERT(a_free_after_last, (done && !cmd_acc) |=> !busy_s1, "command held after last word")
	`LMBP_ASSERT(a_emit_needs_cmd, emit |-> busy_s1, "word emitted with no command")

endmodule
